### src/bsil_pkg.sv
// ----------------------------------------------------------------------------
// Bounded sorted insertion list package
// Shared codes, defaults and the flag bundle passed along the cell chain.
// ----------------------------------------------------------------------------
package bsil_pkg;

   localparam int CAPACITY_DEFAULT  = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int TAG_WIDTH_DEFAULT = 16;

   // Fixed field widths of the ports.
   localparam int OPCODE_W    = 2;
   localparam int PORT_KEY_W  = 32;
   localparam int PORT_TAG_W  = 16;
   localparam int PORT_IDX_W  = 4;
   localparam int PORT_CNT_W  = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;
   localparam int LIMIT_RESET = 16;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LIST_LIMIT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORDER_DESC = 4'd1;

   // Per-cell status: found says the insert position is at or before this cell.
   typedef struct packed {
      logic found;
      logic load;
   } cell_flag_type;

endpackage

### src/bounded_sorted_insert_list_core.sv
// ----------------------------------------------------------------------------
// Bounded sorted insertion list core
// Keeps a sorted top-k list of key/tag entries in a row of cells.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Contents
//  req_     in         req_valid/req_stall   opcode, key, tag, read index
//  rsp_     out        rsp_valid/rsp_stall   key, tag, valid, inserted, dropped, count
//  csr_     in         csr_valid/csr_ready   register index, write data
//
// On every operation all cells compare the new key in parallel
// and a one-bit found flag ripples down the row to pick the insert position.
// A new request is taken in the cycle its predecessor's response transfers, so
// the core sustains one operation per cycle while the response side keeps up.
// Reset empties the list and restores the limit and order registers; the
// stored entries themselves are not cleared. A stalled response holds the
// request side stalled.
//
module bounded_sorted_insert_list_core #(
   parameter int CAPACITY  = bsil_pkg::CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = bsil_pkg::KEY_WIDTH_DEFAULT,
   parameter int TAG_WIDTH = bsil_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bsil_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [bsil_pkg::PORT_KEY_W-1:0]    req_entry_key,
   input  logic [bsil_pkg::PORT_TAG_W-1:0]    req_entry_tag,
   input  logic [bsil_pkg::PORT_IDX_W-1:0]    req_read_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bsil_pkg::PORT_KEY_W-1:0]    rsp_out_key,
   output logic [bsil_pkg::PORT_TAG_W-1:0]    rsp_out_tag,
   output logic                               rsp_out_valid,
   output logic                               rsp_inserted,
   output logic                               rsp_dropped,
   output logic [bsil_pkg::PORT_CNT_W-1:0]    rsp_entry_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bsil_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bsil_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bsil_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = 9;

   logic [CSR_DATA_W-1:0] limit_ff, limit_in;
   logic                  order_ff, order_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PORT_KEY_W-1:0] out_key_ff, out_key_in;
   logic [PORT_TAG_W-1:0] out_tag_ff, out_tag_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  inserted_ff, inserted_in;
   logic                  dropped_ff, dropped_in;
   logic [PORT_CNT_W-1:0] entry_count_ff, entry_count_in;

   logic                  req_take;
   logic                  insert_en;
   logic [WIDE_W-1:0]     lim_wide;
   logic [CNT_W-1:0]      lim;
   logic [CNT_W:0]        count_plus;
   logic                  any_load;
   logic [WIDE_W-1:0]     count_wide;

   logic [KEY_WIDTH+PORT_KEY_W-1:0] key_ext;
   logic [TAG_WIDTH+PORT_TAG_W-1:0] tag_ext;
   logic [KEY_WIDTH-1:0]            new_key;
   logic [TAG_WIDTH-1:0]            new_tag;
   logic [KEY_WIDTH-1:0]            rd_key;
   logic [TAG_WIDTH-1:0]            rd_tag;
   logic [KEY_WIDTH+PORT_KEY_W-1:0] rd_key_ext;
   logic [TAG_WIDTH+PORT_TAG_W-1:0] rd_tag_ext;
   logic                            rd_hit;

   logic [KEY_WIDTH-1:0] cell_key  [CAPACITY];
   logic [TAG_WIDTH-1:0] cell_tag  [CAPACITY];
   cell_flag_type        cell_flag [CAPACITY];
   logic [CAPACITY-1:0]  load_vec;

   assign req_take  = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign csr_ready = 1'b1;
   assign insert_en = req_take && (req_opcode == OP_INSERT);

   // Keys and tags are taken in their low bits and zero-extended as needed.
   assign key_ext = {{KEY_WIDTH{1'b0}}, req_entry_key};
   assign tag_ext = {{TAG_WIDTH{1'b0}}, req_entry_tag};
   assign new_key = key_ext[KEY_WIDTH-1:0];
   assign new_tag = tag_ext[TAG_WIDTH-1:0];

   // A limit above the capacity acts as the capacity.
   assign lim_wide = (WIDE_W'(limit_ff) > WIDE_W'(CAPACITY)) ? WIDE_W'(CAPACITY)
                                                              : WIDE_W'(limit_ff);
   assign lim      = lim_wide[CNT_W-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic [TAG_WIDTH-1:0] left_tag;
      logic                 found_in;
      if (i == 0) begin : g_head
         assign left_key = new_key;
         assign left_tag = new_tag;
         assign found_in = 1'b0;
      end else begin : g_body
         assign left_key = cell_key[i-1];
         assign left_tag = cell_tag[i-1];
         assign found_in = cell_flag[i-1].found;
      end

      bsil_cell #(
         .INDEX     (i),
         .CNT_W     (CNT_W),
         .KEY_WIDTH (KEY_WIDTH),
         .TAG_WIDTH (TAG_WIDTH)
      ) u_cell (
         .clock      (clock),
         .insert_en  (insert_en),
         .order_desc (order_ff),
         .held_count (count_ff),
         .limit      (lim),
         .new_key    (new_key),
         .new_tag    (new_tag),
         .left_key   (left_key),
         .left_tag   (left_tag),
         .found_in   (found_in),
         .cell_key   (cell_key[i]),
         .cell_tag   (cell_tag[i]),
         .flag       (cell_flag[i])
      );

      assign load_vec[i] = cell_flag[i].load;
   end

   assign any_load   = |load_vec;
   assign count_plus = {1'b0, count_ff} + (CNT_W+1)'(any_load);

   always_comb begin
      rd_key = '0;
      rd_tag = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (WIDE_W'(req_read_index) == WIDE_W'(i)) begin
            rd_key = cell_key[i];
            rd_tag = cell_tag[i];
         end
      end
   end

   assign rd_hit     = WIDE_W'(req_read_index) < WIDE_W'(count_ff);
   assign rd_key_ext = {{PORT_KEY_W{1'b0}}, rd_key};
   assign rd_tag_ext = {{PORT_TAG_W{1'b0}}, rd_tag};

   always_comb begin
      count_in     = count_ff;
      out_key_in   = out_key_ff;
      out_tag_in   = out_tag_ff;
      out_valid_in = out_valid_ff;
      inserted_in  = inserted_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         out_key_in   = '0;
         out_tag_in   = '0;
         out_valid_in = 1'b0;
         inserted_in  = 1'b0;
         dropped_in   = 1'b0;
         unique case (req_opcode)
            OP_INSERT: begin
               inserted_in = any_load;
               if (count_plus > {1'b0, lim}) begin
                  count_in   = lim;
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_plus[CNT_W-1:0];
               end
            end
            OP_READ: begin
               if (rd_hit) begin
                  out_key_in   = rd_key_ext[PORT_KEY_W-1:0];
                  out_tag_in   = rd_tag_ext[PORT_TAG_W-1:0];
                  out_valid_in = 1'b1;
               end
            end
            OP_CLEAR: count_in = '0;
            default: ;
         endcase
      end
   end

   assign count_wide     = WIDE_W'(count_in);
   assign entry_count_in = req_take ? count_wide[PORT_CNT_W-1:0] : entry_count_ff;

   always_comb begin
      limit_in = limit_ff;
      order_in = order_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LIST_LIMIT) begin
            limit_in = csr_wdata;
         end else if (csr_index == CSR_ORDER_DESC) begin
            order_in = csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= CSR_DATA_W'(LIMIT_RESET);
         order_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         order_ff     <= order_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_key_ff     <= out_key_in;
      out_tag_ff     <= out_tag_in;
      out_valid_ff   <= out_valid_in;
      inserted_ff    <= inserted_in;
      dropped_ff     <= dropped_in;
      entry_count_ff <= entry_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_out_tag     = out_tag_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_inserted    = inserted_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_entry_count = entry_count_ff;

   // The list never holds more entries than the row has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      WIDE_W'(count_ff) <= WIDE_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // At most one cell takes the new entry.
   a_single_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_vec))
      else $error("more than one cell loaded the new entry");

   // A read never reports an insert, and an insert never reports read data.
   a_flags_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_out_valid && (rsp_inserted || rsp_dropped)))
      else $error("read and insert flags set together");

   // After a drop the list is exactly at its limit.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      insert_en && (count_plus > {1'b0, lim}) |=> count_ff == $past(lim))
      else $error("drop did not leave the list at its limit");

endmodule

### src/bsil_cell.sv
// ----------------------------------------------------------------------------
// Bounded sorted insertion list cell
// Holds one entry; on an insert it keeps its entry, takes the new one, or
// takes its left neighbor's entry as the list moves down by one.
// ----------------------------------------------------------------------------
module bsil_cell #(
   parameter int INDEX     = 0,
   parameter int CNT_W     = 5,
   parameter int KEY_WIDTH = bsil_pkg::KEY_WIDTH_DEFAULT,
   parameter int TAG_WIDTH = bsil_pkg::TAG_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  insert_en,
   input  logic                  order_desc,
   input  logic [CNT_W-1:0]      held_count,
   input  logic [CNT_W-1:0]      limit,
   input  logic [KEY_WIDTH-1:0]  new_key,
   input  logic [TAG_WIDTH-1:0]  new_tag,
   input  logic [KEY_WIDTH-1:0]  left_key,
   input  logic [TAG_WIDTH-1:0]  left_tag,
   input  logic                  found_in,
   output logic [KEY_WIDTH-1:0]  cell_key,
   output logic [TAG_WIDTH-1:0]  cell_tag,
   output bsil_pkg::cell_flag_type flag
);
   import bsil_pkg::*;

   localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic                 follows;
   logic                 cont;
   logic                 shift;

   always_comb begin
      follows = order_desc ? (new_key < key_ff) : (new_key > key_ff);
      // The scan passes this cell only if it is a live entry inside the limit.
      cont       = (POS < limit) && (POS < held_count) && follows;
      flag.found = found_in | ~cont;
      flag.load  = insert_en & ~found_in & ~cont & (POS < limit);
      shift      = insert_en & found_in & (POS <= held_count);
   end

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      priority if (flag.load) begin
         key_in = new_key;
         tag_in = new_tag;
      end else if (shift) begin
         key_in = left_key;
         tag_in = left_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign cell_key = key_ff;
   assign cell_tag = tag_ff;

endmodule
